// File: src/epst_pkg.sv
package epst_pkg;

    localparam int CHG_W      = 32;
    localparam int CPR_W      = 15;
    localparam int GEAR_W     = 16;
    localparam int RATE_W     = 17;
    localparam int PROD_W     = CHG_W + RATE_W;   // mag * rate
    localparam int NUM_W      = PROD_W + 6;       // mag * rate * 60
    localparam int DEN_W      = CPR_W + GEAR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_ZERO   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CNT32 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CPR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GEAR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd3;

    typedef struct packed {
        logic [CPR_W-1:0]  cpr;
        logic [GEAR_W-1:0] gear;
        logic [RATE_W-1:0] rate;
    } t_spd_cfg;

    typedef struct packed {
        logic             start;
        logic             ack;
        logic [CHG_W-1:0] change;
    } t_spd_ctl;

    typedef struct packed {
        logic             done;
        logic [CHG_W-1:0] speed;
    } t_spd_sts;

endpackage

// File: src/epst_speed_unit.sv
module epst_speed_unit #(
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  epst_pkg::t_spd_cfg i_cfg,
    input  epst_pkg::t_spd_ctl i_ctl,
    output epst_pkg::t_spd_sts o_sts
);
    import epst_pkg::*;

    localparam int DIV_STEPS = NUM_W + 8 + SPEED_FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        r_state, n_state;
    logic              r_neg;
    logic [CHG_W-1:0]  r_mag;
    logic [PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [CHG_W:0]    r_q;
    logic              r_ov;
    logic [CNT_W-1:0]  r_cnt;
    logic [CHG_W-1:0]  r_speed;

    // shared multiplier
    logic [CHG_W-1:0]  mul_a;
    logic [RATE_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;

    always_comb begin
        if (r_state == S_MUL1) begin
            mul_a = r_mag;
            mul_b = i_cfg.rate;
        end else begin
            mul_a = CHG_W'(i_cfg.cpr);
            mul_b = RATE_W'(i_cfg.gear);
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // x*60 = x*64 - x*4
    logic [NUM_W-1:0] num60;
    assign num60 = (NUM_W'(r_prod) << 6) - (NUM_W'(r_prod) << 2);

    // one restoring division step
    logic [DEN_W:0] rs, diff;
    logic           ge;
    assign rs   = {r_rem, r_num[NUM_W-1]};
    assign ge   = rs >= {1'b0, r_den};
    assign diff = rs - {1'b0, r_den};

    logic [CHG_W:0]   limit;
    logic             sat;
    logic [CHG_W-1:0] res;
    assign limit = r_neg ? {2'b01, {(CHG_W-1){1'b0}}} : {2'b00, {(CHG_W-1){1'b1}}};
    assign sat   = r_ov || (r_q > limit);
    assign res   = sat ? limit[CHG_W-1:0] : r_q[CHG_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_ctl.start) n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_DIV;
            S_DIV:  if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_FIN;
            S_FIN:  n_state = S_DONE;
            S_DONE: if (i_ctl.ack) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_neg <= i_ctl.change[CHG_W-1];
                r_mag <= i_ctl.change[CHG_W-1] ? (~i_ctl.change + 1'b1) : i_ctl.change;
            end
            S_MUL1: begin
                r_prod <= mul_p;
            end
            S_MUL2: begin
                r_num <= num60;
                r_den <= mul_p[DEN_W-1:0];
                r_rem <= '0;
                r_q   <= '0;
                r_ov  <= 1'b0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
                r_num <= r_num << 1;
                r_ov  <= r_ov | r_q[CHG_W];
                r_q   <= {r_q[CHG_W-1:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_FIN: begin
                if (r_den == '0) begin
                    r_speed <= '0;
                end else begin
                    r_speed <= r_neg ? (~res + 1'b1) : res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.done  = (r_state == S_DONE);
    assign o_sts.speed = r_speed;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_den != '0) |-> (r_rem < r_den))
        else $error("division remainder not below divisor");

    a_pos_speed_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_neg) |-> !r_speed[CHG_W-1])
        else $error("positive change gave negative speed");

    a_ack_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_ctl.ack) |=> (r_state == S_IDLE))
        else $error("speed unit did not release after ack");

endmodule

// File: src/encoder_position_speed_tracker.sv
// channel | valid       | stall        | payload
// input   | i_in_valid  | o_in_stall   | i_command, i_counter_value
// output  | o_out_valid | i_out_stall  | o_position, o_count_change, o_speed_rpm_q8
// config  | i_cfg_we    | -            | i_cfg_idx, i_cfg_data
//
// Each word goes through the bit-serial restoring divider: 63 + SPEED_FRAC_BITS steps.
// A result waits in the output register; a new word is taken once the divider is free
// and the previous result has been loaded there.
// Reset is synchronous, active low; it clears the tracker state and loads config defaults.
module encoder_position_speed_tracker #(
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [epst_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [epst_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [31:0]                         i_counter_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [31:0]                  o_position,
    output logic signed [31:0]                  o_count_change,
    output logic signed [31:0]                  o_speed_rpm_q8
);
    import epst_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_UPD  = 2'd1;
    localparam logic [1:0] T_WAIT = 2'd2;

    localparam logic signed [16:0] NEG_LIM = -17'sd32767;

    logic [1:0]        r_state;
    logic              r_cnt32;
    t_spd_cfg          r_cfg;
    logic [CHG_W-1:0]  r_prev;
    logic [CHG_W-1:0]  r_pos;
    logic [CHG_W-1:0]  r_last;
    logic              r_zero;
    logic              r_out_valid;
    logic [CHG_W-1:0]  r_out_pos, r_out_chg, r_out_spd;

    t_spd_ctl spd_ctl;
    t_spd_sts spd_sts;

    logic in_acc, out_load;
    assign in_acc   = i_in_valid && (r_state == T_IDLE);
    assign out_load = (r_state == T_WAIT) && spd_sts.done && (!r_out_valid || !i_out_stall);

    // wrap-corrected change
    logic [16:0]       d16;
    logic [16:0]       d16_adj;
    logic [CHG_W-1:0]  chg;
    assign d16 = {1'b0, i_counter_value[15:0]} - {1'b0, r_prev[15:0]};
    always_comb begin
        d16_adj = d16;
        if (!d16[16] && d16[15]) begin
            d16_adj = d16 - 17'h10000;
        end else if (d16[16] && ($signed(d16) < NEG_LIM)) begin
            d16_adj = d16 + 17'h10000;
        end
        if (r_cnt32) begin
            chg = i_counter_value - r_prev;
        end else begin
            chg = {{(CHG_W-17){d16_adj[16]}}, d16_adj};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt32   <= 1'b0;
            r_cfg.cpr <= CPR_W'(48);
            r_cfg.gear <= GEAR_W'(256);
            r_cfg.rate <= RATE_W'(1000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CNT32: r_cnt32    <= i_cfg_data[0];
                REG_CPR:   r_cfg.cpr  <= i_cfg_data[CPR_W-1:0];
                REG_GEAR:  r_cfg.gear <= i_cfg_data[GEAR_W-1:0];
                REG_RATE:  r_cfg.rate <= i_cfg_data[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_prev      <= '0;
            r_pos       <= '0;
            r_last      <= '0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                T_IDLE: if (in_acc) begin
                    r_zero <= (i_command == CMD_ZERO);
                    if (i_command == CMD_SAMPLE) begin
                        r_last <= chg;
                        r_prev <= i_counter_value;
                    end
                    r_state <= T_UPD;
                end
                T_UPD: begin
                    r_pos   <= r_zero ? '0 : (r_pos + r_last);
                    r_state <= T_WAIT;
                end
                T_WAIT: if (out_load) r_state <= T_IDLE;
                default: r_state <= T_IDLE;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pos <= r_pos;
            r_out_chg <= r_last;
            r_out_spd <= spd_sts.speed;
        end
    end

    assign spd_ctl.start  = (r_state == T_UPD);
    assign spd_ctl.ack    = out_load;
    assign spd_ctl.change = r_last;

    epst_speed_unit #(
        .SPEED_FRAC_BITS(SPEED_FRAC_BITS)
    ) u_speed (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_ctl  (spd_ctl),
        .o_sts  (spd_sts)
    );

    assign o_in_stall     = (r_state != T_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_position     = r_out_pos;
    assign o_count_change = r_out_chg;
    assign o_speed_rpm_q8 = r_out_spd;

endmodule

// File: dv/epst_checker.sv
module epst_checker #(
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [epst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [epst_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_command,
    input  logic [31:0]                     i_counter_value,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic signed [31:0]              i_position,
    input  logic signed [31:0]              i_count_change,
    input  logic signed [31:0]              i_speed_rpm_q8,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import epst_pkg::*;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] change;
        logic signed [31:0] speed;
    } t_reading;

    // shadow of the config registers
    logic              wide_counter;
    logic [CPR_W-1:0]  cpr;
    logic [GEAR_W-1:0] gear;
    logic [RATE_W-1:0] rate;

    // shadow of the tracker state
    logic [31:0] prev_count;
    logic [31:0] pos_acc;
    logic [31:0] last_delta;

    t_reading expected_readings[$];
    int       mismatches = 0;

    function automatic logic [31:0] wrapped_delta(logic [31:0] now);
        int d;
        if (wide_counter)
            return now - prev_count;
        d = int'({16'd0, now[15:0]}) - int'({16'd0, prev_count[15:0]});
        if (d > 32767)
            d -= 65536;
        else if (d < -32767)
            d += 65536;
        return d;
    endfunction

    // rpm * 2^F = |delta| * rate * 60 * 2^(8+F) / (cpr * gear_q8), clamped per sign
    function automatic logic [31:0] rpm_q8(logic [31:0] delta);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] cap;
        logic [95:0] den;
        logic [95:0] quo;
        den = 96'(cpr) * 96'(gear);
        if (den == 0)
            return 32'd0;
        neg = delta[31];
        mag = neg ? (32'd0 - delta) : delta;
        cap = neg ? 32'h8000_0000 : 32'h7fff_ffff;
        quo = ((96'(mag) * 96'(rate) * 96'd60) << (8 + SPEED_FRAC_BITS)) / den;
        if (quo > 96'(cap))
            quo = 96'(cap);
        return neg ? (32'd0 - quo[31:0]) : quo[31:0];
    endfunction

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_reading want;
        if (!i_rst_n) begin
            wide_counter = 1'b0;
            cpr          = 15'd48;
            gear         = 16'd256;
            rate         = 17'd1000;
            prev_count   = '0;
            pos_acc      = '0;
            last_delta   = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CNT32: wide_counter = i_cfg_data[0];
                    REG_CPR:   cpr          = i_cfg_data[CPR_W-1:0];
                    REG_GEAR:  gear         = i_cfg_data[GEAR_W-1:0];
                    REG_RATE:  rate         = i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    $error("result word with nothing pending: position %0d, change %0d",
                           i_position, i_count_change);
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("position", want.position, i_position);
                    check_field("count_change", want.change, i_count_change);
                    check_field("speed_rpm_q8", want.speed, i_speed_rpm_q8);
                end
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_command == CMD_ZERO) begin
                    pos_acc = '0;
                end else begin
                    last_delta = wrapped_delta(i_counter_value);
                    prev_count = i_counter_value;
                    pos_acc    = pos_acc + last_delta;
                end
                want.position = pos_acc;
                want.change   = last_delta;
                want.speed    = rpm_q8(last_delta);
                expected_readings.push_back(want);
            end
        end
        o_pending    <= expected_readings.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import epst_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_command;
    logic [31:0]           i_counter_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic signed [31:0]    o_position;
    logic signed [31:0]    o_count_change;
    logic signed [31:0]    o_speed_rpm_q8;

    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;

    logic tx_calm = 1'b0;
    logic rx_calm = 1'b0;
    logic hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    encoder_position_speed_tracker uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_counter_value(i_counter_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_position     (o_position),
        .o_count_change (o_count_change),
        .o_speed_rpm_q8 (o_speed_rpm_q8)
    );

    epst_checker tracker_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_counter_value(i_counter_value),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_position     (o_position),
        .i_count_change (o_count_change),
        .i_speed_rpm_q8 (o_speed_rpm_q8),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("encoder_position_speed_tracker: mismatch");
            $finish;
        end
    end

    // receiver: random stall, plus a long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req <= 1'b0;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (rx_calm || !i_rst_n) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 37);
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [31:0] val);
        while (!tx_calm && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_counter_value <= val;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // pending is registered in the checker, so look at it from the next edge on
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // upper data bits are filler the block must drop
    task automatic apply_settings(input logic wide, input logic [CPR_W-1:0] cpr,
                                  input logic [GEAR_W-1:0] gear,
                                  input logic [RATE_W-1:0] rate);
        logic [CFG_DATA_W-1:0] filler;
        filler = CFG_DATA_W'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_CNT32;
        i_cfg_data <= {filler[CFG_DATA_W-1:1], wide};
        @(posedge i_clk);
        i_cfg_idx  <= REG_CPR;
        i_cfg_data <= {filler[1:0], cpr};
        @(posedge i_clk);
        i_cfg_idx  <= REG_GEAR;
        i_cfg_data <= {filler[0], gear};
        @(posedge i_clk);
        i_cfg_idx  <= REG_RATE;
        i_cfg_data <= rate;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                n;
        int                step;
        logic              wide;
        logic [CPR_W-1:0]  cpr;
        logic [GEAR_W-1:0] gear;
        logic [RATE_W-1:0] rate;
        logic [31:0]       tick;
        logic [31:0]       val;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_command       <= CMD_SAMPLE;
        i_counter_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, 16-bit wrap both ways, edges of the wrap window
        send_word(CMD_SAMPLE, 32'h0000_0000);
        send_word(CMD_SAMPLE, 32'h0000_7fff);
        send_word(CMD_SAMPLE, 32'hffff_ffff);
        send_word(CMD_SAMPLE, 32'h1234_7fff);
        send_word(CMD_ZERO,   32'hdead_beef);
        send_word(CMD_SAMPLE, 32'h0000_0001);
        send_word(CMD_SAMPLE, 32'habcd_ffff);
        send_word(CMD_SAMPLE, 32'h5555_0001);
        drain();

        // mode switch to 32 bits, fastest settings: saturation in both signs
        apply_settings(1'b1, 15'd1, 16'd1, 17'd100000);
        send_word(CMD_SAMPLE, 32'h5555_0001);
        send_word(CMD_SAMPLE, 32'hd555_0001);
        send_word(CMD_SAMPLE, 32'h5555_0000);
        send_word(CMD_SAMPLE, 32'h5555_0001);
        send_word(CMD_ZERO,   32'h0000_0000);
        drain();

        // zero counts per rev
        apply_settings(1'b1, 15'd0, 16'd256, 17'd1000);
        send_word(CMD_SAMPLE, 32'h5555_03e9);
        send_word(CMD_SAMPLE, 32'h5555_03e4);
        drain();

        // slowest settings, back to 16 bits: truncation toward zero
        apply_settings(1'b0, 15'h7fff, 16'hffff, 17'd1);
        send_word(CMD_SAMPLE, 32'hffff_0003);
        send_word(CMD_SAMPLE, 32'h0000_0000);
        send_word(CMD_ZERO,   32'hffff_ffff);
        drain();

        // zero gear ratio with a rate beyond range, then zero rate
        apply_settings(1'b1, 15'd48, 16'd0, 17'h1ffff);
        send_word(CMD_SAMPLE, 32'h8000_0000);
        drain();
        apply_settings(1'b1, 15'd48, 16'd256, 17'd0);
        send_word(CMD_SAMPLE, 32'h7fff_0000);
        drain();

        tick = 32'h7fff_0000;
        for (int ph = 0; ph < 12; ph++) begin
            wide = 1'($urandom_range(1));
            case ($urandom_range(7))
                0:       cpr = 15'd0;
                1:       cpr = 15'd1;
                2:       cpr = 15'h7fff;
                default: cpr = CPR_W'($urandom_range(32767, 1));
            endcase
            case ($urandom_range(7))
                0:       gear = 16'd0;
                1:       gear = 16'd1;
                2:       gear = 16'hffff;
                default: gear = GEAR_W'($urandom_range(65535, 1));
            endcase
            case ($urandom_range(9))
                0:       rate = 17'd1;
                1:       rate = 17'd100000;
                2:       rate = 17'h1ffff;
                3:       rate = 17'd0;
                default: rate = RATE_W'($urandom_range(100000, 1));
            endcase
            drain();
            apply_settings(wide, cpr, gear, rate);

            tx_calm = (ph == 3) || (ph == 5);
            rx_calm <= (ph == 3);
            if (ph == 5)
                hold_req <= 1'b1;

            n = $urandom_range(120, 60);
            for (int k = 0; k < n; k++) begin
                if (ph == 7 && k == n / 2)
                    drain();
                case ($urandom_range(99)) inside
                    [0:5]: begin
                        send_word(CMD_ZERO, $urandom);
                    end
                    [6:13]: begin
                        tick = $urandom;
                        send_word(CMD_SAMPLE, tick);
                    end
                    default: begin
                        case ($urandom_range(3))
                            0:       step = $urandom_range(600) - 300;
                            1, 2:    step = $urandom_range(65534) - 32767;
                            default: step = $urandom;
                        endcase
                        tick = tick + step;
                        val  = wide ? tick : {16'($urandom), tick[15:0]};
                        send_word(CMD_SAMPLE, val);
                    end
                endcase
            end
            tx_calm = 1'b0;
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("encoder_position_speed_tracker: match");
        else
            $display("encoder_position_speed_tracker: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
src/epst_pkg.sv
src/epst_speed_unit.sv
src/encoder_position_speed_tracker.sv
dv/epst_checker.sv
dv/tb_top.sv
